### src/i2cts_pkg.sv
// Shared types, widths and constants for the I2C timing divider solver.
package i2cts_pkg;

	localparam int CLK_W   = 25;
	localparam int KHZ_W   = 12;
	localparam int TGT_W   = 22;
	localparam int OPT_W   = 15;
	localparam int SAMP_W  = 4;
	localparam int STEP_W  = 7;
	localparam int PROD_W  = 10;
	localparam int TW_W    = 11;
	localparam int LTW_W   = 9;
	localparam int RATE_W  = 15;

	localparam int DEF_MAX_SAMPLE_COUNT = 8;
	localparam int DEF_MAX_STEP_COUNT   = 64;

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(13650000);
	localparam int HZ_PER_KHZ = 1000;
	localparam int HZ2_PER_KHZ = 2000;

	typedef struct packed {
		logic             bus_index;
		logic [KHZ_W-1:0] requested_khz;
	} req_item_t;

	typedef struct packed {
		logic              bus_tag;
		logic [TW_W-1:0]   timing_word;
		logic [LTW_W-1:0]  low_timing_word;
		logic [RATE_W-1:0] achieved_khz;
		logic              request_error;
	} rsp_item_t;

	typedef struct packed {
		logic             start;
		logic [CLK_W-1:0] dividend;
		logic [TGT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CLK_W-1:0] quotient;
	} div_rsp_t;

endpackage

### src/i2cts_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module i2cts_divider
	import i2cts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(CLK_W);

	logic [CLK_W-1:0] acc_q;
	logic [TGT_W-1:0] rem_q;
	logic [TGT_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [TGT_W:0]   trial;
	logic             fits;
	logic [TGT_W:0]   diff;

	assign trial = {rem_q, acc_q[CLK_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, the quotient bit in at the bottom
			acc_q <= {acc_q[CLK_W-2:0], fits};
			rem_q <= fits ? diff[TGT_W-1:0] : trial[TGT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = acc_q;

endmodule

### src/i2c_timing_divider_solver.sv
// I2C timing divider solver: top level with sequencer and output register.
//
//  channel | direction | handshake               | payload
//  in      | to block  | in_valid / in_stall     | in_data  (req_item_t)
//  out     | from block| out_valid / out_stall   | out_data (rsp_item_t)
//  cfg     | to block  | cfg_wr_en               | cfg_wr_data (bus_clock_hz)
//
// A request runs up to three divisions on the shared radix-2 divider and a search
// over the sample counts; when no sample count fits, the search saturates and skips
// the step division. A zero request skips the divisions and goes straight to done.
// After reset the clock register holds 13650000 Hz and the block is idle.
// A new request is taken while a result still waits in the output register.
// Output stall only holds the block once a second result is ready.
module i2c_timing_divider_solver
	import i2cts_pkg::*;
#(
	parameter int MAX_SAMPLE_COUNT = DEF_MAX_SAMPLE_COUNT,
	parameter int MAX_STEP_COUNT   = DEF_MAX_STEP_COUNT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CLK_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_item_t        in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_item_t        out_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TGT   = 3'd1;
	localparam logic [2:0] ST_OPT   = 3'd2;
	localparam logic [2:0] ST_SRCH  = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_RATE  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam logic [SAMP_W-1:0] SAMP_MAX = SAMP_W'(MAX_SAMPLE_COUNT);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_STEP_COUNT);

	logic [2:0]        state_q;
	logic [CLK_W-1:0]  bus_clk_q;
	logic              tag_q;
	logic [KHZ_W-1:0]  khz_q;
	logic              err_q;
	logic [OPT_W-1:0]  opt_q;
	logic [SAMP_W-1:0] samp_q;
	logic [STEP_W-1:0] step_q;
	logic [RATE_W-1:0] rate_q;
	logic              out_valid_q;
	rsp_item_t         out_data_q;
	logic              div_start_q;
	logic [CLK_W-1:0]  div_dividend_q;
	logic [TGT_W-1:0]  div_divisor_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              in_xfer;
	logic              out_free;
	logic [PROD_W:0]   limit;
	logic              opt_fits;
	logic              div_start;
	logic [SAMP_W-1:0] samp_m1;
	logic [STEP_W-1:0] step_m1;

	i2cts_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req  = {div_start_q, div_dividend_q, div_divisor_q};
	assign in_stall = state_q != ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign limit    = (PROD_W+1)'(STEP_MAX) * (PROD_W+1)'(samp_q);
	assign opt_fits = opt_q <= {{(OPT_W-PROD_W-1){1'b0}}, limit};
	// the target is ready in the cycle after the transfer
	assign div_start = (state_q == ST_TGT) || (state_q == ST_SRCH && opt_fits)
		|| (state_q == ST_MUL);
	assign samp_m1  = samp_q - 1'b1;
	assign step_m1  = step_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clk_q <= CLK_RESET;
		end else if (cfg_wr_en) begin
			bus_clk_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= div_start;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= (in_data.requested_khz == '0) ? ST_DONE : ST_TGT;
					end
				end
				ST_TGT: begin
					state_q <= ST_OPT;
				end
				ST_OPT: begin
					if (div_rsp.done) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (opt_fits) begin
						state_q <= ST_STEP;
					end else if (samp_q == SAMP_MAX) begin
						state_q <= ST_MUL;
					end
				end
				ST_STEP: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_RATE;
				end
				ST_RATE: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					tag_q <= in_data.bus_index;
					khz_q <= in_data.requested_khz;
					err_q <= in_data.requested_khz == '0;
				end
			end
			ST_TGT: begin
				div_dividend_q <= {1'b0, bus_clk_q[CLK_W-1:1]}
					+ {{(CLK_W-TGT_W){1'b0}}, TGT_W'(khz_q * HZ_PER_KHZ)} - 1'b1;
				div_divisor_q  <= TGT_W'(khz_q * HZ_PER_KHZ);
			end
			ST_OPT: begin
				if (div_rsp.done) begin
					// a clock below 2 Hz gives a zero divider: raise it to 1
					opt_q  <= (div_rsp.quotient == '0) ? OPT_W'(1) : div_rsp.quotient[OPT_W-1:0];
					samp_q <= SAMP_W'(1);
				end
			end
			ST_SRCH: begin
				if (opt_fits) begin
					div_dividend_q <= CLK_W'(opt_q) + CLK_W'(samp_m1);
					div_divisor_q  <= TGT_W'(samp_q);
				end else if (samp_q == SAMP_MAX) begin
					step_q <= STEP_MAX;
				end else begin
					samp_q <= samp_q + 1'b1;
				end
			end
			ST_STEP: begin
				if (div_rsp.done) begin
					step_q <= div_rsp.quotient[STEP_W-1:0];
				end
			end
			ST_MUL: begin
				div_dividend_q <= bus_clk_q;
				div_divisor_q  <= TGT_W'(samp_q * step_q * HZ2_PER_KHZ);
			end
			ST_RATE: begin
				if (div_rsp.done) begin
					rate_q <= div_rsp.quotient[RATE_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q.bus_tag       <= tag_q;
					out_data_q.request_error <= err_q;
					if (err_q) begin
						out_data_q.timing_word     <= '0;
						out_data_q.low_timing_word <= '0;
						out_data_q.achieved_khz    <= '0;
					end else begin
						out_data_q.timing_word     <= {samp_m1[2:0], 2'b00, step_m1[5:0]};
						out_data_q.low_timing_word <= {samp_m1[2:0], step_m1[5:0]};
						out_data_q.achieved_khz    <= rate_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	property p_done_in_wait;
		@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_OPT || state_q == ST_STEP || state_q == ST_RATE);
	endproperty
	a_done_in_wait: assert property (p_done_in_wait)
		else $error("divider finished outside a wait state");

	property p_busy_after_xfer;
		@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != ST_IDLE;
	endproperty
	a_busy_after_xfer: assert property (p_busy_after_xfer)
		else $error("sequencer idle after an input transfer");

	property p_error_zeroes;
		@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.request_error) |->
			(out_data.achieved_khz == '0 && out_data.timing_word == '0);
	endproperty
	a_error_zeroes: assert property (p_error_zeroes)
		else $error("error result carries non-zero fields");

	property p_step_fits;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && div_rsp.done) |->
			div_rsp.quotient <= CLK_W'(MAX_STEP_COUNT);
	endproperty
	a_step_fits: assert property (p_step_fits)
		else $error("step count above its limit");

endmodule

### test/i2c_timing_divider_solver_tb.sv
// Self-checking testbench for the I2C timing divider solver.
`timescale 1ns / 1ps

module i2c_timing_divider_solver_tb;
	import i2cts_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam logic [KHZ_W-1:0] CORNER_KHZ [16] = '{
		12'd0, 12'd0, 12'd1, 12'd4095, 12'd2048, 12'd1365, 12'd2730, 12'd13,
		12'd14, 12'd7, 12'd100, 12'd400, 12'd1000, 12'd3400, 12'd3413, 12'd4000
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CLK_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	req_item_t        in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	rsp_item_t        out_data;

	req_item_t        rate_requests [$];
	rsp_item_t        pending_timing [$];
	logic [CLK_W-1:0] bus_clock_hz = CLK_RESET;

	int idle_pct = 0;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int n_queued = 0;
	int n_taken = 0;
	int n_zero = 0;
	int n_checked = 0;
	int n_settings = 0;
	int n_bad = 0;

	i2c_timing_divider_solver u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always #5 clk = ~clk;

	function automatic rsp_item_t solve_timing(req_item_t req, logic [CLK_W-1:0] src_hz);
		rsp_item_t r;
		longint unsigned src, target, opt, samp, steps, rate, st;
		bit fit;
		r = '0;
		r.bus_tag = req.bus_index;
		if (req.requested_khz == 0) begin
			r.request_error = 1'b1;
			return r;
		end
		src = 64'(src_hz);
		target = 64'(req.requested_khz) * HZ_PER_KHZ;
		opt = (src / 2 + target - 1) / target;
		if (opt == 0)
			opt = 1;
		fit = 1'b0;
		samp = DEF_MAX_SAMPLE_COUNT;
		steps = DEF_MAX_STEP_COUNT;
		// first sample count whose step count fits wins; otherwise saturate
		for (longint unsigned s = 1; s <= DEF_MAX_SAMPLE_COUNT && !fit; s++) begin
			st = (opt + s - 1) / s;
			if (st <= DEF_MAX_STEP_COUNT) begin
				fit = 1'b1;
				samp = s;
				steps = st;
			end
		end
		rate = src / (2 * samp * steps) / HZ_PER_KHZ;
		r.timing_word = TW_W'((((samp - 1) & 7) << 8) | ((steps - 1) & 63));
		r.low_timing_word = LTW_W'((((samp - 1) & 7) << 6) | ((steps - 1) & 63));
		r.achieved_khz = RATE_W'(rate);
		return r;
	endfunction

	function automatic void flag(string msg);
		n_bad++;
		if (n_bad <= 10)
			$display("ERROR %0t: %s", $realtime, msg);
	endfunction

	function automatic req_item_t rand_request();
		req_item_t r;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		r.bus_index = 1'($urandom_range(0, 1));
		if (pick == 0)
			r.requested_khz = '0;
		else if (pick < 5)
			r.requested_khz = KHZ_W'($urandom_range(1, 20));
		else if (pick < 12)
			r.requested_khz = KHZ_W'($urandom_range(50, 1000));
		else
			r.requested_khz = KHZ_W'($urandom_range(1, 4095));
		return r;
	endfunction

	// driver: hold the payload while stalled, idle in bursts between transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(0, 7);
			end else if (rate_requests.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= rate_requests.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				bus_clock_hz = cfg_wr_data;
			if (in_valid && !in_stall) begin
				pending_timing.push_back(solve_timing(in_data, bus_clock_hz));
				n_taken++;
				if (in_data.requested_khz == 0)
					n_zero++;
			end
			if (out_valid && !out_stall) begin
				n_checked++;
				if (pending_timing.size() == 0) begin
					flag("result transfer with no request outstanding");
				end else begin
					want = pending_timing.pop_front();
					if (out_data.bus_tag !== want.bus_tag)
						flag($sformatf("bus_tag: expected %0d, got %0d",
							want.bus_tag, out_data.bus_tag));
					if (out_data.timing_word !== want.timing_word)
						flag($sformatf("timing_word: expected 0x%0h, got 0x%0h",
							want.timing_word, out_data.timing_word));
					if (out_data.low_timing_word !== want.low_timing_word)
						flag($sformatf("low_timing_word: expected 0x%0h, got 0x%0h",
							want.low_timing_word, out_data.low_timing_word));
					if (out_data.achieved_khz !== want.achieved_khz)
						flag($sformatf("achieved_khz: expected %0d, got %0d",
							want.achieved_khz, out_data.achieved_khz));
					if (out_data.request_error !== want.request_error)
						flag($sformatf("request_error: expected %0d, got %0d",
							want.request_error, out_data.request_error));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("i2c_timing_divider_solver verification failed");
				$finish;
			end
		end
	end

	task automatic queue_request(input req_item_t req);
		rate_requests.push_back(req);
		n_queued++;
	endtask

	task automatic wait_results();
		while (n_checked < n_queued)
			@(posedge clk);
	endtask

	task automatic random_batch(input int n);
		for (int i = 0; i < n; i++)
			queue_request(rand_request());
		wait_results();
	endtask

	task automatic set_bus_clock(input logic [CLK_W-1:0] hz);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	// write the clock while idle, then run two batches with a full drain between
	task automatic run_phase(input logic [CLK_W-1:0] hz, input int n, input int pct);
		set_bus_clock(hz);
		idle_pct = pct;
		random_batch(n / 2);
		random_batch(n - n / 2);
	endtask

	initial begin
		req_item_t d;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 20;
		foreach (CORNER_KHZ[i]) begin
			d.bus_index = i[0];
			d.requested_khz = CORNER_KHZ[i];
			queue_request(d);
		end
		wait_results();
		random_batch(40);
		random_batch(40);
		run_phase(CLK_W'(1000000), 80, 25);
		run_phase({CLK_W{1'b1}}, 80, 15);
		run_phase(CLK_W'($urandom_range(1000000, 33554431)), 80, 0);
		// degenerate source clocks: divider clamps to one
		run_phase(CLK_W'(1), 10, 30);
		run_phase('0, 10, 30);
		run_phase(CLK_W'($urandom()), 80, 35);
		run_phase(CLK_W'($urandom_range(1000000, 33554431)), 80, 20);
		run_phase(CLK_RESET, 80, 10);
		run_phase(CLK_W'($urandom_range(1000000, 33554431)), 60, 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_timing.size() != 0)
			flag($sformatf("%0d results never arrived", pending_timing.size()));
		$display("covered %0d rate requests (%0d zero-rate) over %0d written bus clocks",
			n_taken, n_zero, n_settings);
		$display("checked %0d results, %0d failures", n_checked, n_bad);
		if (n_bad == 0)
			$display("i2c_timing_divider_solver verification clean");
		else
			$display("i2c_timing_divider_solver verification failed");
		$finish;
	end

endmodule

### filelist.f
src/i2cts_pkg.sv
src/i2cts_divider.sv
src/i2c_timing_divider_solver.sv
test/i2c_timing_divider_solver_tb.sv
